// ===== hdl/sfs_pkg.sv =====
// Shared constants, types and the sequencer microprogram for the floor search block.
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_W     = 8;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;

    // Operation codes of an input word
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_INIT  = 3'd1;
    localparam logic [STEP_W-1:0] S_FIRST = 3'd2;
    localparam logic [STEP_W-1:0] S_STEP  = 3'd3;
    localparam logic [STEP_W-1:0] S_EMIT  = 3'd4;

    // Datapath actions
    localparam int DP_W = 3;
    localparam logic [DP_W-1:0] DP_IDLE  = 3'd0;
    localparam logic [DP_W-1:0] DP_INIT  = 3'd1;
    localparam logic [DP_W-1:0] DP_FIRST = 3'd2;
    localparam logic [DP_W-1:0] DP_STEP  = 3'd3;
    localparam logic [DP_W-1:0] DP_EMIT  = 3'd4;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_START      = 3'd0;
    localparam logic [COND_W-1:0] C_EMPTY      = 3'd1;
    localparam logic [COND_W-1:0] C_FIRST_DONE = 3'd2;
    localparam logic [COND_W-1:0] C_STEP_DONE  = 3'd3;
    localparam logic [COND_W-1:0] C_OUT_FREE   = 3'd4;

    // One control word of the microprogram
    typedef struct packed {
        logic [DP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] next_true;
        logic [STEP_W-1:0] next_false;
    } t_ctrl;

    // Table write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VALUE_W-1:0] data;
    } t_ram_wr;

    // Microprogram ROM
    function automatic t_ctrl ucode_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            S_IDLE:  w = '{op: DP_IDLE,  cond: C_START,      next_true: S_INIT,
                           next_false: S_IDLE};
            S_INIT:  w = '{op: DP_INIT,  cond: C_EMPTY,      next_true: S_EMIT,
                           next_false: S_FIRST};
            S_FIRST: w = '{op: DP_FIRST, cond: C_FIRST_DONE, next_true: S_EMIT,
                           next_false: S_STEP};
            S_STEP:  w = '{op: DP_STEP,  cond: C_STEP_DONE,  next_true: S_EMIT,
                           next_false: S_STEP};
            S_EMIT:  w = '{op: DP_EMIT,  cond: C_OUT_FREE,   next_true: S_IDLE,
                           next_false: S_EMIT};
            default: w = '{op: DP_IDLE,  cond: C_START,      next_true: S_IDLE,
                           next_false: S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sfs_channels.sv =====
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
`default_nettype none
interface sfs_req_if import sfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [ADDR_W-1:0]  entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic [VALUE_W-1:0] needle;

    modport source (output valid, operation, entry_index, entry_value, needle,
                    input ready);
    modport sink   (input valid, operation, entry_index, entry_value, needle,
                    output ready);
endinterface

interface sfs_rsp_if import sfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] floor_index;

    modport source (output valid, found, floor_index, input ready);
    modport sink   (input valid, found, floor_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/sorted_table_floor_search_core.sv =====
// Top level: sorted table with microcoded binary floor search.
//
// Usage: software writes the table through i_req words with operation 0
// (entry_index, entry_value) and sets entries_in_use through i_cfg_we /
// i_cfg_wdata while the block is idle. A word with operation 1 searches for
// needle and gives one o_rsp word: found and the largest index whose entry
// is at most the needle (floor_index 0 when not found). Write words give none.
// Flow: a search probes the table over the single read port, one probe per
// cycle, until its interval closes (with no probe for an empty table), then
// writes the result register. No word is accepted while a search runs; the
// next word is accepted once the sequencer is back at its idle step.
// Stall: the result sits in an output register; while it waits, further
// write and search words are accepted and a search runs, holding at its last
// step until the register frees.
// Reset: clears entries_in_use, the sequencer and the result valid, and holds
// i_req ready low; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_floor_search_core import sfs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    sfs_req_if.sink                i_req,
    sfs_rsp_if.source              o_rsp
);

    // sequencer and datapath registers
    logic [STEP_W-1:0]  r_step, n_step;
    logic [SIZE_W-1:0]  r_size;
    logic [VALUE_W-1:0] r_needle;
    logic [ADDR_W-1:0]  r_lo, n_lo;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic               r_found;
    logic               r_out_valid;
    logic               r_out_found;
    logic [ADDR_W-1:0]  r_out_index;

    t_ctrl              ctrl;
    logic               cond_hit;
    logic               accept;
    logic               out_free;
    logic [SIZE_W-1:0]  size_sat;
    logic [VALUE_W-1:0] rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               below_first;
    logic               ge_probe;
    logic [ADDR_W:0]    mid_sum_cur;
    logic [ADDR_W:0]    mid_sum_nxt;
    logic [ADDR_W-1:0]  mid_cur;
    logic [ADDR_W-1:0]  mid_nxt;
    t_ram_wr            ram_wr;

    assign ctrl     = ucode_rom(r_step);
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (ctrl.op == DP_IDLE) && i_rst_n;

    // table write from write words
    assign ram_wr.we   = accept && (i_req.operation == OP_WRITE);
    assign ram_wr.addr = i_req.entry_index;
    assign ram_wr.data = i_req.entry_value;

    sfs_table_ram u_table (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // size in use, saturated to the table depth
    assign size_sat = (r_size > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : r_size;

    // probe compare and interval update
    assign below_first = r_needle < rd_data;
    assign ge_probe    = r_needle >= rd_data;
    assign mid_sum_cur = {1'b0, r_lo} + {1'b0, r_hi} + (ADDR_W+1)'(1);
    assign mid_cur     = mid_sum_cur[ADDR_W:1];

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (ctrl.op == DP_STEP) begin
            if (ge_probe) begin
                n_lo = r_mid;
            end else begin
                n_hi = r_mid - ADDR_W'(1);
            end
        end
    end

    assign mid_sum_nxt = {1'b0, n_lo} + {1'b0, n_hi} + (ADDR_W+1)'(1);
    assign mid_nxt     = mid_sum_nxt[ADDR_W:1];

    // read address by step: first entry, first midpoint, then next midpoint
    always_comb begin
        case (ctrl.op)
            DP_INIT:  rd_addr = '0;
            DP_FIRST: rd_addr = mid_cur;
            DP_STEP:  rd_addr = mid_nxt;
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        case (ctrl.op)
            DP_FIRST: n_mid = mid_cur;
            DP_STEP:  n_mid = mid_nxt;
            default:  n_mid = r_mid;
        endcase
    end

    // jump condition select
    always_comb begin
        case (ctrl.cond)
            C_START:      cond_hit = accept && (i_req.operation == OP_SEARCH);
            C_EMPTY:      cond_hit = (size_sat == '0);
            C_FIRST_DONE: cond_hit = below_first || (r_lo >= r_hi);
            C_STEP_DONE:  cond_hit = (n_lo >= n_hi);
            C_OUT_FREE:   cond_hit = out_free;
            default:      cond_hit = 1'b0;
        endcase
    end

    assign n_step = cond_hit ? ctrl.next_true : ctrl.next_false;

    // step counter and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_size <= '0;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (ctrl.op == DP_IDLE && accept) begin
            r_needle <= i_req.needle;
        end
        case (ctrl.op)
            DP_INIT: begin
                r_lo    <= '0;
                r_hi    <= ADDR_W'(size_sat - SIZE_W'(1));
                r_found <= 1'b0;
            end
            DP_FIRST: begin
                r_found <= !below_first;
                r_mid   <= n_mid;
            end
            DP_STEP: begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= n_mid;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == DP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == DP_EMIT && out_free) begin
            r_out_found <= r_found;
            r_out_index <= r_found ? r_lo : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.floor_index = r_out_index;

endmodule
`default_nettype wire

// ===== hdl/sfs_table_ram.sv =====
// Table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module sfs_table_ram import sfs_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_ram_wr            i_wr,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic      [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire
